FILE: rtl/bilinear_image_upscaler_defines.svh
// ----------------------------------------------------------------------------
// Bilinear upscaler assertion macros
// Shared property shorthands for the upscaler RTL.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_UPSCALER_DEFINES_SVH
`define BILINEAR_IMAGE_UPSCALER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define BIU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BIU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/biu_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear upscaler package
// Sizes, register codes and the sideband type shared by the upscaler RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package biu_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;

  localparam int COORD_W    = 13;
  localparam int DIM_W      = 9;
  localparam int SCALE_W    = 13;
  localparam int SCALE_FRAC = 8;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;

  localparam int XA_W = $clog2(MAX_WIDTH);
  localparam int YA_W = $clog2(MAX_HEIGHT);

  // output extent = (scale * (src + 1)) >> SCALE_FRAC
  localparam int EXT_W  = SCALE_W + DIM_W - SCALE_FRAC;
  localparam int DIVD_W = COORD_W + DIM_W + FRAC_BITS;
  localparam int DIVS_W = EXT_W;
  localparam int QUO_W  = DIM_W + FRAC_BITS;
  localparam int WGT_W  = 2 * FRAC_BITS + 1;

  localparam int BANK_AW    = (XA_W - 1) + (YA_W - 1);
  localparam int BANK_DEPTH = 2 ** BANK_AW;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 2'd2;

  localparam logic [DIM_W-1:0]   SRC_WIDTH_RST  = DIM_W'(256);
  localparam logic [DIM_W-1:0]   SRC_HEIGHT_RST = DIM_W'(256);
  localparam logic [SCALE_W-1:0] SCALE_RST      = SCALE_W'(512);

  // item info that rides alongside the divider stages
  typedef struct packed {
    logic            vld;
    logic            req;
    logic            ok;     // write in frame, or request inside output
    logic            one_x;  // output axis has at most one pixel
    logic            one_y;
    logic [XA_W-1:0] x;
    logic [YA_W-1:0] y;
    logic [PIX_W-1:0] pix;
  } sb_t;

endpackage

`default_nettype wire

FILE: rtl/biu_div.sv
// ----------------------------------------------------------------------------
// Upscaler divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module biu_div (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire [biu_pkg::DIVD_W-1:0]    dividend_i,
  input  wire [biu_pkg::DIVS_W-1:0]    divisor_i,
  output logic [biu_pkg::QUO_W-1:0]    quotient_o
);

  localparam int QW = biu_pkg::QUO_W;
  localparam int RW = biu_pkg::DIVS_W;

  logic [RW-1:0] rem_q [QW];
  logic [QW-1:0] num_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [RW-1:0] den_q [QW];

  // quotient is known to fit QW bits, so the top dividend bits start below the divisor
  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [RW-1:0] rem_in;
    logic [RW-1:0] den_in;
    logic [QW-1:0] num_in;
    logic [QW-1:0] quo_in;
    logic [RW:0]   trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = RW'(dividend_i[biu_pkg::DIVD_W-1:QW]);
      assign num_in = dividend_i[QW-1:0];
      assign quo_in = '0;
      assign den_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign trial = {rem_in, num_in[QW-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? RW'(trial - {1'b0, den_in}) : trial[RW-1:0];
        num_q[s] <= {num_in[QW-2:0], 1'b0};
        quo_q[s] <= {quo_in[QW-2:0], ge};
        den_q[s] <= den_in;
      end
    end
  end

  assign quotient_o = quo_q[QW-1];

endmodule

`default_nettype wire

FILE: rtl/biu_ram.sv
// ----------------------------------------------------------------------------
// Upscaler frame bank
// One parity bank of the source frame: one write port, one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module biu_ram (
  input  wire                          clk_i,
  input  wire                          we_i,
  input  wire [biu_pkg::BANK_AW-1:0]   waddr_i,
  input  wire [biu_pkg::PIX_W-1:0]     wdata_i,
  input  wire                          re_i,
  input  wire [biu_pkg::BANK_AW-1:0]   raddr_i,
  output logic [biu_pkg::PIX_W-1:0]    rdata_o
);

  logic [biu_pkg::PIX_W-1:0] mem [biu_pkg::BANK_DEPTH];
  logic [biu_pkg::PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/bilinear_image_upscaler.sv
// Bilinear image upscaler. Source pixels are written into an on-chip frame
// (up to 256x256 RGB, four banks split by column and row parity so that the
// 2x2 neighborhood of any output pixel is fetched in parallel, one read port
// per bank). Requests for output pixels of the scaled image are answered in
// order, one item per clock while the output does not stall; a write item
// gives no result. Each item passes from input accept to the output register
// through three setup stages, seventeen stages of the pipelined coordinate
// divider (one quotient bit each, which sets the depth), address, frame read,
// weight and blend stages. A stall at the output freezes the whole pipe.
// Configuration registers may only be written while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_image_upscaler_defines.svh"

// ----------------------------------------------------------------------------
// Bilinear image upscaler
// Frame store plus bilinear resampling pipeline, one pixel per clock when not stalled.
// ----------------------------------------------------------------------------
module bilinear_image_upscaler (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // config write port
  input  wire                              cfg_we_i,
  input  wire [biu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [biu_pkg::SCALE_W-1:0]       cfg_data_i,
  // input items
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              req_type_i,
  input  wire [biu_pkg::COORD_W-1:0]       coord_x_i,
  input  wire [biu_pkg::COORD_W-1:0]       coord_y_i,
  input  wire [biu_pkg::CH_W-1:0]          pixel_red_i,
  input  wire [biu_pkg::CH_W-1:0]          pixel_green_i,
  input  wire [biu_pkg::CH_W-1:0]          pixel_blue_i,
  // result items
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [biu_pkg::CH_W-1:0]         out_red_o,
  output logic [biu_pkg::CH_W-1:0]         out_green_o,
  output logic [biu_pkg::CH_W-1:0]         out_blue_o,
  output logic                             status_o
);

  localparam int CW  = biu_pkg::COORD_W;
  localparam int DW  = biu_pkg::DIM_W;
  localparam int EW  = biu_pkg::EXT_W;
  localparam int QW  = biu_pkg::QUO_W;
  localparam int FB  = biu_pkg::FRAC_BITS;
  localparam int XW  = biu_pkg::XA_W;
  localparam int YW  = biu_pkg::YA_W;
  localparam int PW  = biu_pkg::PIX_W;
  localparam int CHW = biu_pkg::CH_W;
  localparam int WW  = biu_pkg::WGT_W;
  localparam int AW  = biu_pkg::BANK_AW;
  localparam int ACC_W = CHW + WW + 2;
  localparam int PRW = biu_pkg::SCALE_W + DW;
  localparam int XPW = CW + DW;

  // whole pipe moves when the output register is free or being drained
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // --------------------------------------------------------------------------
  // Configuration registers (source dimensions saturated on write)
  // --------------------------------------------------------------------------
  function automatic logic [DW-1:0] sat_dim(input logic [DW-1:0] v,
                                            input logic [DW-1:0] hi);
    logic [DW-1:0] r;
    r = v;
    if (v == '0) r = DW'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  logic [DW-1:0]              src_w_q, src_h_q;
  logic [biu_pkg::SCALE_W-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= biu_pkg::SRC_WIDTH_RST;
      src_h_q <= biu_pkg::SRC_HEIGHT_RST;
      scale_q <= biu_pkg::SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        biu_pkg::REG_SRC_WIDTH:
          src_w_q <= sat_dim(cfg_data_i[DW-1:0], DW'(biu_pkg::MAX_WIDTH));
        biu_pkg::REG_SRC_HEIGHT:
          src_h_q <= sat_dim(cfg_data_i[DW-1:0], DW'(biu_pkg::MAX_HEIGHT));
        biu_pkg::REG_SCALE:
          scale_q <= cfg_data_i;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // S1: capture
  // --------------------------------------------------------------------------
  logic           s1_vld_q, s1_req_q;
  logic [CW-1:0]  s1_x_q, s1_y_q;
  logic [PW-1:0]  s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_req_q <= req_type_i;
      s1_x_q   <= coord_x_i;
      s1_y_q   <= coord_y_i;
      s1_pix_q <= {pixel_blue_i, pixel_green_i, pixel_red_i};
    end
  end

  // --------------------------------------------------------------------------
  // S2: output extents, write bounds
  // --------------------------------------------------------------------------
  logic [PRW-1:0] wprod, hprod;
  assign wprod = PRW'(scale_q) * PRW'(src_w_q + DW'(1));
  assign hprod = PRW'(scale_q) * PRW'(src_h_q + DW'(1));

  logic           s2_vld_q, s2_req_q, s2_wok_q;
  logic [CW-1:0]  s2_x_q, s2_y_q;
  logic [PW-1:0]  s2_pix_q;
  logic [EW-1:0]  s2_wout_q, s2_hout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_req_q  <= s1_req_q;
      s2_x_q    <= s1_x_q;
      s2_y_q    <= s1_y_q;
      s2_pix_q  <= s1_pix_q;
      s2_wok_q  <= (s1_x_q < CW'(src_w_q)) && (s1_y_q < CW'(src_h_q));
      s2_wout_q <= wprod[PRW-1:biu_pkg::SCALE_FRAC];
      s2_hout_q <= hprod[PRW-1:biu_pkg::SCALE_FRAC];
    end
  end

  // --------------------------------------------------------------------------
  // S3: range check, dividend x*src*2^FB, divisor extent-1
  // --------------------------------------------------------------------------
  logic [XPW-1:0] xprod, yprod;
  assign xprod = XPW'(s2_x_q) * XPW'(src_w_q);
  assign yprod = XPW'(s2_y_q) * XPW'(src_h_q);

  logic in_rng;
  assign in_rng = (EW'(s2_x_q) < s2_wout_q) && (EW'(s2_y_q) < s2_hout_q);

  biu_pkg::sb_t                 s3_sb_q;
  logic [biu_pkg::DIVD_W-1:0]   s3_dvx_q, s3_dvy_q;
  logic [EW-1:0]                s3_dsx_q, s3_dsy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_sb_q <= '0;
    end else if (adv) begin
      s3_sb_q.vld   <= s2_vld_q;
      s3_sb_q.req   <= s2_req_q;
      s3_sb_q.ok    <= s2_req_q ? in_rng : s2_wok_q;
      s3_sb_q.one_x <= (s2_wout_q <= EW'(1));
      s3_sb_q.one_y <= (s2_hout_q <= EW'(1));
      s3_sb_q.x     <= s2_x_q[XW-1:0];
      s3_sb_q.y     <= s2_y_q[YW-1:0];
      s3_sb_q.pix   <= s2_pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_dvx_q <= {xprod, {FB{1'b0}}};
      s3_dvy_q <= {yprod, {FB{1'b0}}};
      s3_dsx_q <= s2_wout_q - EW'(1);
      s3_dsy_q <= s2_hout_q - EW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages; sideband shifts along
  // --------------------------------------------------------------------------
  logic [QW-1:0] qx, qy;

  biu_div u_div_x (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (s3_dvx_q),
    .divisor_i  (s3_dsx_q),
    .quotient_o (qx)
  );

  biu_div u_div_y (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (s3_dvy_q),
    .divisor_i  (s3_dsy_q),
    .quotient_o (qy)
  );

  biu_pkg::sb_t dv_sb_q [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QW; i++) dv_sb_q[i] <= '0;
    end else if (adv) begin
      dv_sb_q[0] <= s3_sb_q;
      for (int i = 1; i < QW; i++) dv_sb_q[i] <= dv_sb_q[i-1];
    end
  end

  biu_pkg::sb_t dsb;
  assign dsb = dv_sb_q[QW-1];

  // --------------------------------------------------------------------------
  // S4: source indices, clamps, fractions
  // --------------------------------------------------------------------------
  logic [QW-1:0] ux, uy;
  logic [DW-1:0] kx, ky, xlo, xhi, ylo, yhi, xlo_r, ylo_r, wm1, hm1;

  assign ux  = dsb.one_x ? '0 : qx + QW'(1 << (FB - 1));
  assign uy  = dsb.one_y ? '0 : qy + QW'(1 << (FB - 1));
  assign kx  = ux[QW-1:FB];
  assign ky  = uy[QW-1:FB];
  assign wm1 = src_w_q - DW'(1);
  assign hm1 = src_h_q - DW'(1);

  assign xlo_r = (kx == '0) ? '0 : kx - DW'(1);
  assign ylo_r = (ky == '0) ? '0 : ky - DW'(1);
  assign xlo   = (xlo_r > wm1) ? wm1 : xlo_r;
  assign ylo   = (ylo_r > hm1) ? hm1 : ylo_r;
  assign xhi   = (kx > wm1) ? wm1 : kx;
  assign yhi   = (ky > hm1) ? hm1 : ky;

  logic           s4_vld_q, s4_req_q, s4_ok_q;
  logic [XW-1:0]  s4_x0_q, s4_x1_q;
  logic [YW-1:0]  s4_y0_q, s4_y1_q;
  logic [FB-1:0]  s4_fx_q, s4_fy_q;
  logic [PW-1:0]  s4_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (adv) begin
      s4_vld_q <= dsb.vld;
    end
  end

  // a write uses x0/y0 as its own address
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_req_q <= dsb.req;
      s4_ok_q  <= dsb.ok;
      s4_x0_q  <= dsb.req ? xlo[XW-1:0] : dsb.x;
      s4_x1_q  <= dsb.req ? xhi[XW-1:0] : dsb.x;
      s4_y0_q  <= dsb.req ? ylo[YW-1:0] : dsb.y;
      s4_y1_q  <= dsb.req ? yhi[YW-1:0] : dsb.y;
      s4_fx_q  <= ux[FB-1:0];
      s4_fy_q  <= uy[FB-1:0];
      s4_pix_q <= dsb.pix;
    end
  end

  // --------------------------------------------------------------------------
  // Frame banks, indexed {row parity, column parity}
  // --------------------------------------------------------------------------
  logic [XW-2:0] col_a [2];
  logic [YW-2:0] row_a [2];
  logic [PW-1:0] rd [4];
  logic          wr;

  assign wr = adv && s4_vld_q && !s4_req_q && s4_ok_q;

  for (genvar p = 0; p < 2; p++) begin : g_par
    assign col_a[p] = (s4_x0_q[0] == 1'(p)) ? s4_x0_q[XW-1:1] : s4_x1_q[XW-1:1];
    assign row_a[p] = (s4_y0_q[0] == 1'(p)) ? s4_y0_q[YW-1:1] : s4_y1_q[YW-1:1];
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    biu_ram u_ram (
      .clk_i   (clk_i),
      .we_i    (wr && (s4_x0_q[0] == 1'(b % 2)) && (s4_y0_q[0] == 1'(b / 2))),
      .waddr_i ({s4_y0_q[YW-1:1], s4_x0_q[XW-1:1]}),
      .wdata_i (s4_pix_q),
      .re_i    (adv),
      .raddr_i ({row_a[b / 2], col_a[b % 2]}),
      .rdata_o (rd[b])
    );
  end

  // --------------------------------------------------------------------------
  // S5: alongside the bank read
  // --------------------------------------------------------------------------
  logic          s5_vld_q, s5_req_q, s5_ok_q;
  logic          s5_x0p_q, s5_x1p_q, s5_y0p_q, s5_y1p_q;
  logic [FB-1:0] s5_fx_q, s5_fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (adv) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_req_q <= s4_req_q;
      s5_ok_q  <= s4_ok_q;
      s5_x0p_q <= s4_x0_q[0];
      s5_x1p_q <= s4_x1_q[0];
      s5_y0p_q <= s4_y0_q[0];
      s5_y1p_q <= s4_y1_q[0];
      s5_fx_q  <= s4_fx_q;
      s5_fy_q  <= s4_fy_q;
    end
  end

  // --------------------------------------------------------------------------
  // S6: neighbor select, 2-D weights
  // --------------------------------------------------------------------------
  logic [FB:0] wx0, wx1, wy0, wy1;
  assign wx0 = (FB+1)'(1 << FB) - (FB+1)'(s5_fx_q);
  assign wy0 = (FB+1)'(1 << FB) - (FB+1)'(s5_fy_q);
  assign wx1 = (FB+1)'(s5_fx_q);
  assign wy1 = (FB+1)'(s5_fy_q);

  logic          s6_vld_q, s6_req_q, s6_ok_q;
  logic [PW-1:0] s6_p_q [4];   // p00, p10, p01, p11
  logic [WW-1:0] s6_w_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (adv) begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_req_q  <= s5_req_q;
      s6_ok_q   <= s5_ok_q;
      s6_p_q[0] <= rd[{s5_y0p_q, s5_x0p_q}];
      s6_p_q[1] <= rd[{s5_y0p_q, s5_x1p_q}];
      s6_p_q[2] <= rd[{s5_y1p_q, s5_x0p_q}];
      s6_p_q[3] <= rd[{s5_y1p_q, s5_x1p_q}];
      s6_w_q[0] <= WW'(wx0) * WW'(wy0);
      s6_w_q[1] <= WW'(wx1) * WW'(wy0);
      s6_w_q[2] <= WW'(wx0) * WW'(wy1);
      s6_w_q[3] <= WW'(wx1) * WW'(wy1);
    end
  end

  // --------------------------------------------------------------------------
  // Blend and output register
  // --------------------------------------------------------------------------
  logic [CHW-1:0] blend [3];

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [ACC_W-1:0] acc;
    assign acc = ACC_W'(s6_p_q[0][c*CHW +: CHW]) * ACC_W'(s6_w_q[0])
               + ACC_W'(s6_p_q[1][c*CHW +: CHW]) * ACC_W'(s6_w_q[1])
               + ACC_W'(s6_p_q[2][c*CHW +: CHW]) * ACC_W'(s6_w_q[2])
               + ACC_W'(s6_p_q[3][c*CHW +: CHW]) * ACC_W'(s6_w_q[3]);
    assign blend[c] = acc[2*FB +: CHW];
  end

  logic           out_vld_q, out_st_q;
  logic [CHW-1:0] out_r_q, out_g_q, out_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s6_vld_q && s6_req_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_st_q <= !s6_ok_q;
      out_r_q  <= s6_ok_q ? blend[0] : '0;
      out_g_q  <= s6_ok_q ? blend[1] : '0;
      out_b_q  <= s6_ok_q ? blend[2] : '0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = out_st_q;
  assign out_red_o   = out_r_q;
  assign out_green_o = out_g_q;
  assign out_blue_o  = out_b_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BIU_ASSERT_IMP(a_err_zero, out_vld_q && out_st_q,
    (out_r_q == '0) && (out_g_q == '0) && (out_b_q == '0), "error item carries color")
  `BIU_ASSERT_IMP(a_col_adj, s4_vld_q && s4_req_q && s4_ok_q,
    (s4_x0_q <= s4_x1_q) && (XW'(s4_x1_q - s4_x0_q) <= XW'(1)), "columns not adjacent")
  `BIU_ASSERT_IMP(a_row_adj, s4_vld_q && s4_req_q && s4_ok_q,
    (s4_y0_q <= s4_y1_q) && (YW'(s4_y1_q - s4_y0_q) <= YW'(1)), "rows not adjacent")
  `BIU_ASSERT_NXT(a_stall_hold, !adv,
    $stable(s4_vld_q) && $stable(s4_x0_q) && $stable(s6_vld_q), "pipe moved in stall")

endmodule

`default_nettype wire
